// ===== rtl/iqr_pkg.sv =====
// shared constants and types for the integer quadratic root solver
`default_nettype none
package iqr_pkg;

    localparam int COEF_WIDTH = 16;
    localparam int ROOT_WIDTH = 17;
    localparam int MID_DEPTH  = 4;
    localparam int OUT_DEPTH  = 2;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_DOUBLE = 2'd1,
        ST_TWO    = 2'd2,
        ST_AZERO  = 2'd3
    } status_t;

    typedef struct packed {
        logic    valid;
        status_t status;
    } tag_t;

endpackage
`default_nettype wire

// ===== rtl/iqr_fifo.sv =====
// small register queue with occupancy count
`default_nettype none
module iqr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    input  wire logic [WIDTH-1:0]             din,
    input  wire logic                         pop,
    output logic      [WIDTH-1:0]             dout,
    output logic                              empty,
    output logic      [$clog2(DEPTH+1)-1:0]   count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout  = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule
`default_nettype wire

// ===== rtl/iqr_front.sv =====
// front end: products, discriminant and classification
`default_nettype none
module iqr_front #(
    parameter int COEF_WIDTH = iqr_pkg::COEF_WIDTH,
    parameter int MID_DEPTH  = iqr_pkg::MID_DEPTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    input  wire logic signed [COEF_WIDTH-1:0]        coef_a,
    input  wire logic signed [COEF_WIDTH-1:0]        coef_b,
    input  wire logic signed [COEF_WIDTH-1:0]        coef_c,
    input  wire logic        [$clog2(MID_DEPTH+1)-1:0] mid_count,
    output logic                                     full,
    output logic                                     mid_push,
    output logic [2+(2*COEF_WIDTH+2)+2*(COEF_WIDTH+1)-1:0] mid_data
);

    localparam int W   = COEF_WIDTH;
    localparam int DW  = 2 * W + 2;
    localparam int DSW = 2 * W + 3;
    localparam int CW  = $clog2(MID_DEPTH + 1);
    localparam int SW  = CW + 1;

    logic                  s1_valid_reg;
    logic signed [W-1:0]   a_reg;
    logic signed [W-1:0]   b_reg;
    logic signed [W-1:0]   c_reg;
    logic                  s2_valid_reg;
    logic signed [2*W-1:0] bb_reg;
    logic signed [2*W-1:0] ac_reg;
    logic                  a_zero_reg;
    logic signed [W:0]     nb_reg;
    logic signed [W:0]     twoa_reg;

    logic signed [2*W-1:0] bb_next;
    logic signed [2*W-1:0] ac_next;
    logic signed [DSW-1:0] d;
    logic [SW-1:0]         inflight;
    iqr_pkg::status_t      status;

    assign inflight = SW'(mid_count) + SW'(s1_valid_reg) + SW'(s2_valid_reg);
    assign full     = (inflight >= SW'(MID_DEPTH));

    assign bb_next = b_reg * b_reg;
    assign ac_next = a_reg * c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= push && !full;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= coef_a;
        b_reg      <= coef_b;
        c_reg      <= coef_c;
        bb_reg     <= bb_next;
        ac_reg     <= ac_next;
        a_zero_reg <= (a_reg == '0);
        nb_reg     <= -$signed({b_reg[W-1], b_reg});
        twoa_reg   <= $signed({a_reg, 1'b0});
    end

    assign d = DSW'(bb_reg) - (DSW'(ac_reg) <<< 2);

    always_comb
    begin
        priority if (a_zero_reg)
            status = iqr_pkg::ST_AZERO;
        else if (d < 0)
            status = iqr_pkg::ST_NONE;
        else if (d == '0)
            status = iqr_pkg::ST_DOUBLE;
        else
            status = iqr_pkg::ST_TWO;
    end

    assign mid_push = s2_valid_reg;
    assign mid_data = {status, d[DW-1:0], nb_reg, twoa_reg};

endmodule
`default_nettype wire

// ===== rtl/iqr_sqrt.sv =====
// pipelined integer square root, one root bit per stage
`default_nettype none
module iqr_sqrt #(
    parameter int COEF_WIDTH = iqr_pkg::COEF_WIDTH
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        adv,
    input  wire iqr_pkg::tag_t               in_tag,
    input  wire logic [2*COEF_WIDTH+1:0]     in_d,
    input  wire logic signed [COEF_WIDTH:0]  in_nb,
    input  wire logic signed [COEF_WIDTH:0]  in_twoa,
    output iqr_pkg::tag_t                    out_tag,
    output logic [COEF_WIDTH:0]              out_root,
    output logic signed [COEF_WIDTH:0]       out_nb,
    output logic signed [COEF_WIDTH:0]       out_twoa
);

    localparam int W    = COEF_WIDTH;
    localparam int DW   = 2 * W + 2;
    localparam int RW   = W + 1;
    localparam int SQ   = W + 1;
    localparam int REMW = W + 2;
    localparam int SHW  = W + 4;

    iqr_pkg::tag_t     tag_reg  [SQ];
    logic [REMW-1:0]   rem_reg  [SQ];
    logic [RW-1:0]     root_reg [SQ];
    logic [DW-1:0]     dsh_reg  [SQ];
    logic signed [W:0] nb_reg   [SQ];
    logic signed [W:0] twoa_reg [SQ];

    iqr_pkg::tag_t     tag_in  [SQ];
    logic [REMW-1:0]   rem_in  [SQ];
    logic [RW-1:0]     root_in [SQ];
    logic [DW-1:0]     dsh_in  [SQ];
    logic signed [W:0] nb_in   [SQ];
    logic signed [W:0] twoa_in [SQ];

    for (genvar i = 0; i < SQ; i++)
    begin : g_stage
        logic [SHW-1:0]  rem_sh;
        logic [SHW-1:0]  trial;
        logic            ge;
        logic [SHW-1:0]  rem_diff;
        logic [REMW-1:0] rem_next;
        logic [RW-1:0]   root_next;

        if (i == 0)
        begin : g_first
            assign tag_in[i]  = in_tag;
            assign rem_in[i]  = '0;
            assign root_in[i] = '0;
            assign dsh_in[i]  = in_d;
            assign nb_in[i]   = in_nb;
            assign twoa_in[i] = in_twoa;
        end
        else
        begin : g_rest
            assign tag_in[i]  = tag_reg[i-1];
            assign rem_in[i]  = rem_reg[i-1];
            assign root_in[i] = root_reg[i-1];
            assign dsh_in[i]  = dsh_reg[i-1];
            assign nb_in[i]   = nb_reg[i-1];
            assign twoa_in[i] = twoa_reg[i-1];
        end

        assign rem_sh    = {rem_in[i], dsh_in[i][DW-1 -: 2]};
        assign trial     = SHW'({root_in[i], 2'b01});
        assign ge        = (rem_sh >= trial);
        assign rem_diff  = rem_sh - trial;
        assign rem_next  = ge ? rem_diff[REMW-1:0] : rem_sh[REMW-1:0];
        assign root_next = {root_in[i][RW-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[i] <= '0;
            end
            else if (adv)
            begin
                tag_reg[i] <= tag_in[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                dsh_reg[i]  <= {dsh_in[i][DW-3:0], 2'b00};
                nb_reg[i]   <= nb_in[i];
                twoa_reg[i] <= twoa_in[i];
            end
        end
    end

    assign out_tag  = tag_reg[SQ-1];
    assign out_root = root_reg[SQ-1];
    assign out_nb   = nb_reg[SQ-1];
    assign out_twoa = twoa_reg[SQ-1];

endmodule
`default_nettype wire

// ===== rtl/iqr_div.sv =====
// two-lane pipelined signed division truncating toward zero, one quotient bit per stage
`default_nettype none
module iqr_div #(
    parameter int COEF_WIDTH = iqr_pkg::COEF_WIDTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          adv,
    input  wire iqr_pkg::tag_t                 in_tag,
    input  wire logic signed [COEF_WIDTH+2:0]  in_num1,
    input  wire logic signed [COEF_WIDTH+2:0]  in_num2,
    input  wire logic signed [COEF_WIDTH:0]    in_den,
    output iqr_pkg::tag_t                      out_tag,
    output logic signed [COEF_WIDTH+2:0]       out_quot1,
    output logic signed [COEF_WIDTH+2:0]       out_quot2
);

    localparam int W   = COEF_WIDTH;
    localparam int NW  = W + 3;
    localparam int DNW = W + 1;

    iqr_pkg::tag_t    p_tag_reg;
    logic [NW-1:0]    p_mag_reg [2];
    logic             p_neg_reg [2];
    logic [DNW-1:0]   p_den_reg;

    logic signed [NW-1:0] num_in [2];

    iqr_pkg::tag_t    tag_reg [NW];
    logic [DNW-1:0]   den_reg [NW];
    logic [DNW-1:0]   rem_reg [NW][2];
    logic [NW-1:0]    nsh_reg [NW][2];
    logic [NW-1:0]    q_reg   [NW][2];
    logic             neg_reg [NW][2];

    iqr_pkg::tag_t    tag_in [NW];
    logic [DNW-1:0]   den_in [NW];
    logic [DNW-1:0]   rem_in [NW][2];
    logic [NW-1:0]    nsh_in [NW][2];
    logic [NW-1:0]    q_in   [NW][2];
    logic             neg_in [NW][2];

    logic [NW-1:0]    q_last [2];
    logic signed [NW-1:0] quot [2];

    assign num_in[0] = in_num1;
    assign num_in[1] = in_num2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_tag_reg <= '0;
        end
        else if (adv)
        begin
            p_tag_reg <= in_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_den_reg <= in_den[W] ? DNW'(-in_den) : DNW'(in_den);
            for (int l = 0; l < 2; l++)
            begin
                p_mag_reg[l] <= num_in[l][NW-1] ? NW'(-num_in[l]) : NW'(num_in[l]);
                p_neg_reg[l] <= num_in[l][NW-1] ^ in_den[W];
            end
        end
    end

    for (genvar k = 0; k < NW; k++)
    begin : g_stage
        if (k == 0)
        begin : g_first
            assign tag_in[k] = p_tag_reg;
            assign den_in[k] = p_den_reg;
        end
        else
        begin : g_rest
            assign tag_in[k] = tag_reg[k-1];
            assign den_in[k] = den_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[k] <= '0;
            end
            else if (adv)
            begin
                tag_reg[k] <= tag_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                den_reg[k] <= den_in[k];
            end
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [DNW:0]   rem_sh;
            logic           ge;
            logic [DNW:0]   rem_diff;

            if (k == 0)
            begin : g_src_first
                assign rem_in[k][l] = '0;
                assign nsh_in[k][l] = p_mag_reg[l];
                assign q_in[k][l]   = '0;
                assign neg_in[k][l] = p_neg_reg[l];
            end
            else
            begin : g_src_rest
                assign rem_in[k][l] = rem_reg[k-1][l];
                assign nsh_in[k][l] = nsh_reg[k-1][l];
                assign q_in[k][l]   = q_reg[k-1][l];
                assign neg_in[k][l] = neg_reg[k-1][l];
            end

            assign rem_sh   = {rem_in[k][l], nsh_in[k][l][NW-1]};
            assign ge       = (rem_sh >= {1'b0, den_in[k]});
            assign rem_diff = rem_sh - {1'b0, den_in[k]};

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k][l] <= ge ? rem_diff[DNW-1:0] : rem_sh[DNW-1:0];
                    nsh_reg[k][l] <= {nsh_in[k][l][NW-2:0], 1'b0};
                    q_reg[k][l]   <= {q_in[k][l][NW-2:0], ge};
                    neg_reg[k][l] <= neg_in[k][l];
                end
            end
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_out
        assign q_last[l] = q_reg[NW-1][l];
        assign quot[l]   = neg_reg[NW-1][l] ? -$signed(q_last[l]) : $signed(q_last[l]);
    end

    assign out_tag   = tag_reg[NW-1];
    assign out_quot1 = quot[0];
    assign out_quot2 = quot[1];

endmodule
`default_nettype wire

// ===== rtl/integer_quadratic_roots.sv =====
// integer quadratic root solver top level
//
//   channel   direction  handshake          fields
//   coef      in         push / full        coef_a, coef_b, coef_c
//   root      out        empty / pop        root_status, root_first, root_second
//
// takes one coefficient set per cycle unless full, gives one result per cycle unless empty
// a request passes through two front stages, the middle queue, COEF_WIDTH+1 square root
// stages, COEF_WIDTH+4 division stages and the result queue before its result can be
// popped
// the front stops taking requests once the middle queue and front stages hold MID_DEPTH
// the back pipeline holds while its last stage waits on a full result queue
// reset clears all valid flags and queue pointers; no clearing pass
`default_nettype none
module integer_quadratic_roots #(
    parameter int COEF_WIDTH = iqr_pkg::COEF_WIDTH
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 push,
    output logic                                      full,
    input  wire logic signed [COEF_WIDTH-1:0]         coef_a,
    input  wire logic signed [COEF_WIDTH-1:0]         coef_b,
    input  wire logic signed [COEF_WIDTH-1:0]         coef_c,
    output logic                                      empty,
    input  wire logic                                 pop,
    output logic [1:0]                                root_status,
    output logic signed [iqr_pkg::ROOT_WIDTH-1:0]     root_first,
    output logic signed [iqr_pkg::ROOT_WIDTH-1:0]     root_second
);

    localparam int W    = COEF_WIDTH;
    localparam int DW   = 2 * W + 2;
    localparam int RW   = W + 1;
    localparam int NW   = W + 3;
    localparam int RTW  = iqr_pkg::ROOT_WIDTH;
    localparam int MDW  = 2 + DW + 2 * (W + 1);
    localparam int ODW  = 2 + 2 * RTW;
    localparam int MCW  = $clog2(iqr_pkg::MID_DEPTH + 1);
    localparam int OCW  = $clog2(iqr_pkg::OUT_DEPTH + 1);

    logic              mid_push;
    logic [MDW-1:0]    mid_din;
    logic              mid_pop;
    logic [MDW-1:0]    mid_dout;
    logic              mid_empty;
    logic [MCW-1:0]    mid_count;

    iqr_pkg::tag_t     sq_in_tag;
    iqr_pkg::tag_t     sq_tag;
    logic [RW-1:0]     sq_root;
    logic signed [W:0] sq_nb;
    logic signed [W:0] sq_twoa;

    logic signed [NW-1:0] nb_ext;
    logic signed [NW-1:0] r_ext;
    logic signed [NW-1:0] num1;
    logic signed [NW-1:0] num2;

    iqr_pkg::tag_t        dv_tag;
    logic signed [NW-1:0] quot1;
    logic signed [NW-1:0] quot2;

    logic                 adv;
    logic                 out_push;
    logic [ODW-1:0]       out_din;
    logic [ODW-1:0]       out_dout;
    logic [OCW-1:0]       out_count;
    logic                 out_full;
    logic signed [RTW-1:0] first_val;
    logic signed [RTW-1:0] second_val;

    iqr_front #(
        .COEF_WIDTH (COEF_WIDTH),
        .MID_DEPTH  (iqr_pkg::MID_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .coef_a    (coef_a),
        .coef_b    (coef_b),
        .coef_c    (coef_c),
        .mid_count (mid_count),
        .full      (full),
        .mid_push  (mid_push),
        .mid_data  (mid_din)
    );

    iqr_fifo #(
        .WIDTH (MDW),
        .DEPTH (iqr_pkg::MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .din   (mid_din),
        .pop   (mid_pop),
        .dout  (mid_dout),
        .empty (mid_empty),
        .count (mid_count)
    );

    assign out_full = (out_count == OCW'(iqr_pkg::OUT_DEPTH));
    assign adv      = !(dv_tag.valid && out_full);
    assign mid_pop  = adv && !mid_empty;

    assign sq_in_tag = '{valid:  !mid_empty,
                         status: iqr_pkg::status_t'(mid_dout[MDW-1 -: 2])};

    iqr_sqrt #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_tag   (sq_in_tag),
        .in_d     (mid_dout[MDW-3 -: DW]),
        .in_nb    ($signed(mid_dout[2*(W+1)-1 -: W+1])),
        .in_twoa  ($signed(mid_dout[W:0])),
        .out_tag  (sq_tag),
        .out_root (sq_root),
        .out_nb   (sq_nb),
        .out_twoa (sq_twoa)
    );

    assign nb_ext = NW'(sq_nb);
    assign r_ext  = $signed(NW'(sq_root));
    assign num1   = nb_ext + r_ext;
    assign num2   = nb_ext - r_ext;

    iqr_div #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_tag    (sq_tag),
        .in_num1   (num1),
        .in_num2   (num2),
        .in_den    (sq_twoa),
        .out_tag   (dv_tag),
        .out_quot1 (quot1),
        .out_quot2 (quot2)
    );

    assign first_val  = ((dv_tag.status == iqr_pkg::ST_DOUBLE) ||
                         (dv_tag.status == iqr_pkg::ST_TWO)) ? RTW'(quot1) : '0;
    assign second_val = (dv_tag.status == iqr_pkg::ST_TWO) ? RTW'(quot2) : '0;
    assign out_push   = adv && dv_tag.valid;
    assign out_din    = {dv_tag.status, first_val, second_val};

    iqr_fifo #(
        .WIDTH (ODW),
        .DEPTH (iqr_pkg::OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .din   (out_din),
        .pop   (pop && !empty),
        .dout  (out_dout),
        .empty (empty),
        .count (out_count)
    );

    assign root_status = out_dout[ODW-1 -: 2];
    assign root_first  = $signed(out_dout[2*RTW-1 -: RTW]);
    assign root_second = $signed(out_dout[RTW-1:0]);

    assert property (@(posedge clk) disable iff (!rst_n)
        mid_push |-> (mid_count != MCW'(iqr_pkg::MID_DEPTH)))
    else $error("middle queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
    else $error("result queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (root_status == iqr_pkg::ST_AZERO)) |->
            ((root_first == '0) && (root_second == '0)))
    else $error("roots not cleared for zero leading coefficient");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (root_status == iqr_pkg::ST_DOUBLE)) |-> (root_second == '0))
    else $error("second root not cleared for double root");

endmodule
`default_nettype wire
